// ===== design/cort_pkg.sv =====
// Shared types and codes for the composition offset run table.
// Used by cort_ctrl, cort_dpath and the top level; depends on nothing.
package cort_pkg;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_LOOKUP = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_LOAD   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ORDER    = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_BADINDEX = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic eval;
      logic set_last;
      logic add_gap;
      logic add_run;
      logic load_raw;
      logic clear;
      logic read_issue;
      logic read_take;
      logic walk_step;
      logic result_load;
   } cort_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic [2:0] op;
      logic       append_ok;
      logic       gap_nz;
      logic       run_nz;
      logic       walk_done;
   } cort_stat_type;

endpackage

// ===== design/cort_ctrl.sv =====
// Sequencing state machine of the composition offset run table.
// Depends on cort_pkg for the command and status structs and the opcodes.
module cort_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output cort_pkg::cort_cmd_type  cmd,
   input  cort_pkg::cort_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_GAP,
      S_RUN,
      S_WALK,
      S_RDWAIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               cort_pkg::OP_APPEND: begin
                  cmd.eval = 1'b1;
                  state_in = S_CHECK;
               end
               cort_pkg::OP_LOOKUP: state_in = S_WALK;
               cort_pkg::OP_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = S_RDWAIT;
               end
               cort_pkg::OP_LOAD: begin
                  cmd.load_raw = 1'b1;
                  state_in     = S_DONE;
               end
               cort_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_CHECK: begin
            if (!stat.append_ok) begin
               state_in = S_DONE;
            end else begin
               cmd.set_last = 1'b1;
               if (stat.gap_nz) begin
                  state_in = S_GAP;
               end else if (stat.run_nz) begin
                  state_in = S_RUN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_GAP: begin
            cmd.add_gap = 1'b1;
            state_in    = stat.run_nz ? S_RUN : S_DONE;
         end
         S_RUN: begin
            cmd.add_run = 1'b1;
            state_in    = S_DONE;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_done) begin
               state_in = S_DONE;
            end
         end
         S_RDWAIT: begin
            cmd.read_take = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/cort_dpath.sv =====
// Datapath of the composition offset run table: entry memory, open-entry copy,
// append checks, lookup accumulator and result register. Depends on cort_pkg.
module cort_dpath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cort_pkg::cort_cmd_type  cmd,
   output cort_pkg::cort_stat_type stat,
   input  logic [2:0]              req_opcode,
   input  logic [31:0]             req_sample_number,
   input  logic [31:0]             req_run_count,
   input  logic [31:0]             req_offset,
   input  logic [7:0]              req_entry_index,
   output logic [2:0]              rsp_status,
   output logic [31:0]             rsp_found_offset,
   output logic [31:0]             rsp_entry_run,
   output logic [8:0]              rsp_entries_used,
   output logic [31:0]             rsp_final_sample
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = 32 + AW;
   localparam logic [CW:0] DEPTH_W = (CW + 1)'(TABLE_DEPTH);

   // Entry memory: count in the low half, offset in the high half.
   logic [63:0]   mem [TABLE_DEPTH];
   logic [63:0]   rd_data_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [63:0]   wr_data;

   // Architectural state.
   logic [CW-1:0] count_ff, count_in;
   logic          open_ff, open_in;
   logic [31:0]   last_ff, last_in;
   // Copy of the last entry, always equal to mem[count - 1] when count is nonzero.
   logic [31:0]   cache_cnt_ff, cache_cnt_in;
   logic [31:0]   cache_off_ff, cache_off_in;

   // Captured transaction.
   logic [2:0]    op_ff;
   logic [31:0]   sn_ff, rc_ff, off_ff;
   logic [7:0]    idx_ff;

   // Per-item working registers.
   logic [2:0]    status_ff;
   logic [31:0]   found_off_ff, found_run_ff;
   logic          ok_ff, gap_nz_ff, run_nz_ff, idx_ok_ff;
   logic [31:0]   gap_ff, new_last_ff;
   logic [CW-1:0] issued_ff;
   logic          rdv_ff, hit_ff;
   logic [SW-1:0] sum_ff;

   // Result register.
   logic [2:0]    res_status_ff;
   logic [31:0]   res_off_ff, res_run_ff, res_final_ff;
   logic [8:0]    res_used_ff;

   // Append evaluation.
   logic          e_order, e_over, e_open, e_gap_new, e_run_new, e_full, e_o_open;
   logic [31:0]   e_gap, e_o_off;
   logic [32:0]   e_new_last;
   logic [1:0]    e_needed;
   logic [CW:0]   e_need_sum;

   always_comb begin
      e_order    = (last_ff != 32'd0) && (last_ff >= sn_ff);
      e_gap      = (last_ff != 32'd0) ? (sn_ff - last_ff - 32'd1) : 32'd0;
      e_new_last = (last_ff == 32'd0) ? {1'b0, rc_ff}
                                      : ({1'b0, sn_ff} + {1'b0, rc_ff} - 33'd1);
      e_over     = e_new_last[32];
      e_open     = open_ff && (count_ff != '0);
      e_gap_new  = (e_gap != 32'd0) && !(e_open && (cache_off_ff == 32'd0));
      e_o_open   = e_open || (e_gap != 32'd0);
      e_o_off    = (e_gap != 32'd0) ? 32'd0 : cache_off_ff;
      e_run_new  = (rc_ff != 32'd0) && !(e_o_open && (e_o_off == off_ff));
      e_needed   = {1'b0, e_gap_new} + {1'b0, e_run_new};
      e_need_sum = {1'b0, count_ff} + (CW + 1)'(e_needed);
      e_full     = e_need_sum > DEPTH_W;
   end

   // Lookup walk.
   logic          w_issue, w_hit, w_done;
   logic [SW-1:0] w_sum;
   logic [CW-1:0] last_idx;
   logic [31:0]   idx_ext;
   logic          idx_ok;

   assign w_issue  = cmd.walk_step && !hit_ff && (issued_ff < count_ff);
   assign w_sum    = sum_ff + SW'(rd_data_ff[31:0]);
   assign w_hit    = cmd.walk_step && rdv_ff && !hit_ff && (w_sum >= SW'(sn_ff));
   assign w_done   = hit_ff || ((issued_ff == count_ff) && !rdv_ff);
   assign last_idx = count_ff - CW'(1);
   assign idx_ext  = 32'(idx_ff);
   assign idx_ok   = (idx_ext < 32'(count_ff)) && (idx_ext < 32'(TABLE_DEPTH));

   // Append steps, raw loads and the memory write port.
   logic          a_step, a_merge;
   logic [31:0]   a_n, a_o;
   logic          raw_ok;

   assign raw_ok = {1'b0, count_ff} < DEPTH_W;

   always_comb begin
      a_step       = cmd.add_gap || cmd.add_run;
      a_n          = cmd.add_run ? rc_ff : gap_ff;
      a_o          = cmd.add_run ? off_ff : 32'd0;
      a_merge      = open_ff && (count_ff != '0) && (cache_off_ff == a_o);
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = {a_o, a_n};
      count_in     = count_ff;
      open_in      = open_ff;
      last_in      = last_ff;
      cache_cnt_in = cache_cnt_ff;
      cache_off_in = cache_off_ff;
      if (a_step) begin
         wr_en = 1'b1;
         if (a_merge) begin
            wr_addr      = last_idx[AW-1:0];
            wr_data      = {a_o, cache_cnt_ff + a_n};
            cache_cnt_in = cache_cnt_ff + a_n;
         end else begin
            cache_cnt_in = a_n;
            cache_off_in = a_o;
            count_in     = count_ff + CW'(1);
            open_in      = 1'b1;
         end
      end else if (cmd.load_raw && raw_ok) begin
         wr_en        = 1'b1;
         wr_data      = {off_ff, rc_ff};
         cache_cnt_in = rc_ff;
         cache_off_in = off_ff;
         count_in     = count_ff + CW'(1);
         open_in      = 1'b0;
      end else if (cmd.clear) begin
         count_in = '0;
         open_in  = 1'b0;
         last_in  = 32'd0;
      end
      if (cmd.set_last) begin
         last_in = new_last_ff;
      end
      rd_en   = w_issue || cmd.read_issue;
      rd_addr = cmd.read_issue ? idx_ext[AW-1:0] : issued_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= 1'b0;
         last_ff  <= 32'd0;
      end else begin
         count_ff <= count_in;
         open_ff  <= open_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cache_cnt_ff <= cache_cnt_in;
      cache_off_ff <= cache_off_in;
      if (cmd.capture) begin
         op_ff        <= req_opcode;
         sn_ff        <= req_sample_number;
         rc_ff        <= req_run_count;
         off_ff       <= req_offset;
         idx_ff       <= req_entry_index;
         status_ff    <= cort_pkg::ST_OK;
         found_off_ff <= 32'd0;
         found_run_ff <= 32'd0;
         issued_ff    <= '0;
         rdv_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         sum_ff       <= '0;
      end
      if (cmd.eval) begin
         gap_ff      <= e_gap;
         new_last_ff <= e_new_last[31:0];
         gap_nz_ff   <= (e_gap != 32'd0);
         run_nz_ff   <= (rc_ff != 32'd0);
         ok_ff       <= !(e_order || e_over || e_full);
         if (e_order || e_over) begin
            status_ff <= cort_pkg::ST_ORDER;
         end else if (e_full) begin
            status_ff <= cort_pkg::ST_FULL;
         end
      end
      if (cmd.load_raw && !raw_ok) begin
         status_ff <= cort_pkg::ST_FULL;
      end
      if (cmd.read_issue) begin
         idx_ok_ff <= idx_ok;
         if (!idx_ok) begin
            status_ff <= cort_pkg::ST_BADINDEX;
         end
      end
      if (cmd.read_take && idx_ok_ff) begin
         found_off_ff <= rd_data_ff[63:32];
         found_run_ff <= rd_data_ff[31:0];
      end
      if (cmd.walk_step) begin
         rdv_ff <= w_issue;
         if (w_issue) begin
            issued_ff <= issued_ff + CW'(1);
         end
         if (rdv_ff && !hit_ff) begin
            sum_ff <= w_sum;
         end
         if (w_hit) begin
            hit_ff       <= 1'b1;
            found_off_ff <= rd_data_ff[63:32];
         end
         if (w_done && !hit_ff) begin
            status_ff <= cort_pkg::ST_NOTFOUND;
         end
      end
      if (cmd.result_load) begin
         res_status_ff <= status_ff;
         res_off_ff    <= found_off_ff;
         res_run_ff    <= found_run_ff;
         res_used_ff   <= 9'(count_ff);
         res_final_ff  <= last_ff;
      end
   end

   always_comb begin
      stat.op        = op_ff;
      stat.append_ok = ok_ff;
      stat.gap_nz    = gap_nz_ff;
      stat.run_nz    = run_nz_ff;
      stat.walk_done = w_done;
   end

   assign rsp_status       = res_status_ff;
   assign rsp_found_offset = res_off_ff;
   assign rsp_entry_run    = res_run_ff;
   assign rsp_entries_used = res_used_ff;
   assign rsp_final_sample = res_final_ff;

endmodule

// ===== design/composition_offset_run_table.sv =====
// Top level of the composition offset run table: joins controller and datapath.
// Depends on cort_pkg, cort_ctrl and cort_dpath.

// The block keeps a run-length table of per-sample composition offsets as
// (count, offset) entries in a single-port-write, single-port-read memory of
// TABLE_DEPTH words. Each request transaction gives exactly one response
// transaction. Requests are handled one at a time. An append fills a zero-offset
// gap first where one is needed. A lookup walks the table through the memory's
// read port, which fetches one entry a cycle while a running sum of counts is
// compared with the requested sample number. The result sits in an output
// register, so a new request is taken while the previous response is still
// waiting to be collected. The memory needs no clearing after reset; only
// entries below the used count ever reach a result.
module composition_offset_run_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata, from bit 0 up: sample_number[31:0], run_count[31:0],
   // offset[31:0] (two's complement), entry_index[7:0].
   input  logic [103:0] req_tdata,
   // req_tuser: opcode[2:0].
   input  logic [2:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rsp_tdata, from bit 0 up: found_offset[31:0] (two's complement),
   // entry_run[31:0], entries_used[8:0], final_sample[31:0], zero padding.
   output logic [111:0] rsp_tdata,
   // rsp_tuser: status[2:0].
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   cort_pkg::cort_cmd_type  cmd;
   cort_pkg::cort_stat_type stat;

   logic [31:0] found_offset, entry_run, final_sample;
   logic [8:0]  entries_used;

   // The controller sequences each transaction through the datapath.
   cort_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath only captures the request when the controller accepts it.
   cort_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_tuser),
      .req_sample_number (req_tdata[31:0]),
      .req_run_count     (req_tdata[63:32]),
      .req_offset        (req_tdata[95:64]),
      .req_entry_index   (req_tdata[103:96]),
      .rsp_status        (rsp_tuser),
      .rsp_found_offset  (found_offset),
      .rsp_entry_run     (entry_run),
      .rsp_entries_used  (entries_used),
      .rsp_final_sample  (final_sample)
   );

   assign rsp_tdata = {7'd0, final_sample, entries_used, entry_run, found_offset};

endmodule

// ===== design/cort_checker.sv =====
// Port-level assertions for the composition offset run table, with the bind
// that attaches them to composition_offset_run_table. Depends on cort_pkg.
module cort_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input logic         clock,
   input logic         reset,
   input logic [103:0] req_tdata,
   input logic [2:0]   req_tuser,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [111:0] rsp_tdata,
   input logic [2:0]   rsp_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready
);

   // A response that is held back keeps its contents.
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Requests are processed one at a time.
   one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in progress");

   // A failed transaction returns no entry data.
   error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != cort_pkg::ST_OK) |->
         (rsp_tdata[31:0] == 32'd0) && (rsp_tdata[63:32] == 32'd0))
      else $error("error response carries entry data");

   // The used count never passes the table size.
   used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (TABLE_DEPTH > 511) || (int'(rsp_tdata[72:64]) <= TABLE_DEPTH))
      else $error("entries_used exceeds table depth");

endmodule

bind composition_offset_run_table cort_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for composition_offset_run_table over its request and response streams.
// Depends on cort_pkg for the operation and status codes and on the block's top level.

module tb_top;

   localparam int TABLE_DEPTH  = 256;
   localparam int IDLE_PCT     = 23;    // chance per cycle that either side holds off
   localparam int STALL_LIMIT  = 4000;  // cycles without any transaction before giving up
   localparam int DRAIN_CYCLES = 300;   // about one full-table lookup

   // Operation codes that the block leaves unused; it answers them with an ok status.
   localparam logic [2:0] OP_SPARE     = 3'd5;
   localparam logic [2:0] OP_SPARE_TOP = 3'd7;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        sample_number;
      logic [31:0]        run_count;
      logic signed [31:0] offset;
      logic [7:0]         entry_index;
   } offset_request_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] found_offset;
      logic [31:0]        entry_run;
      logic [8:0]         entries_used;
      logic [31:0]        final_sample;
   } offset_result_type;

   // One row of the directed table. Where known is set, the response is typed in
   // beside the request; otherwise the predictor supplies it.
   typedef struct {
      offset_request_type req;
      bit                 known;
      offset_result_type  want;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [103:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   // While steady is high neither side idles. It is only ever changed with a
   // nonblocking assignment, so every reader at a clock edge sees the same value.
   logic         steady = 1'b0;

   // The predictor's own copy of the run table and its bookkeeping.
   logic [31:0]  tbl_count [TABLE_DEPTH];
   logic [31:0]  tbl_offset [TABLE_DEPTH];
   int unsigned  used_n = 0;
   bit           run_open = 1'b0;
   logic [31:0]  last_sn = '0;

   offset_result_type expected_results [$];
   plan_row_type      plan_q [$];
   int                fault_count = 0;
   int                stall_cycles = 0;

   composition_offset_run_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reset is held high at the start, released once, and never raised again.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic offset_request_type mk_req(input logic [2:0] op, input logic [31:0] sn,
                                                 input logic [31:0] rc, input logic [31:0] off,
                                                 input logic [7:0] idx);
      offset_request_type r;
      r.opcode        = op;
      r.sample_number = sn;
      r.run_count     = rc;
      r.offset        = off;
      r.entry_index   = idx;
      return r;
   endfunction

   // Offset of the open run, or zero when no run is open.
   function automatic logic [31:0] open_offset();
      return (run_open && used_n > 0) ? tbl_offset[used_n - 1] : 32'd0;
   endfunction

   // Adds n samples of one offset, merging into the open run where the offsets agree.
   // Room in the table has already been checked.
   function automatic void extend_table(input logic [31:0] off, input logic [31:0] n);
      if (n == 0) return;
      if (run_open && used_n > 0 && tbl_offset[used_n - 1] == off) begin
         tbl_count[used_n - 1] += n;
      end else begin
         tbl_count[used_n]  = n;
         tbl_offset[used_n] = off;
         used_n++;
         run_open = 1'b1;
      end
   endfunction

   // Works out the response to one accepted request and moves the table state on.
   function automatic offset_result_type apply_request(input offset_request_type r);
      offset_result_type res;
      logic [31:0]       gap;
      logic [31:0]       open_off;
      logic [32:0]       new_last;
      logic [40:0]       walk_sum;
      int unsigned       needed;
      bit                open;
      res = '0;
      res.status = cort_pkg::ST_OK;
      case (r.opcode)
         cort_pkg::OP_APPEND: begin
            open     = run_open && used_n > 0;
            open_off = open_offset();
            gap      = '0;
            needed   = 0;
            if (last_sn != 0) begin
               if (last_sn >= r.sample_number) res.status = cort_pkg::ST_ORDER;
               else gap = r.sample_number - last_sn - 32'd1;
            end
            new_last = {1'b0, last_sn} + {1'b0, gap} + {1'b0, r.run_count};
            // The last sample of the run must still fit in 32 bits.
            if (res.status == cort_pkg::ST_OK && new_last[32]) res.status = cort_pkg::ST_ORDER;
            if (res.status == cort_pkg::ST_OK) begin
               if (gap != 0) begin
                  if (!(open && open_off == 0)) needed++;
                  open     = 1'b1;
                  open_off = '0;
               end
               if (r.run_count != 0 && !(open && open_off == r.offset)) needed++;
               if (used_n + needed > TABLE_DEPTH) res.status = cort_pkg::ST_FULL;
            end
            if (res.status == cort_pkg::ST_OK) begin
               extend_table(32'd0, gap);
               extend_table(r.offset, r.run_count);
               last_sn = new_last[31:0];
            end
         end
         cort_pkg::OP_LOOKUP: begin
            walk_sum   = '0;
            res.status = cort_pkg::ST_NOTFOUND;
            for (int i = 0; i < used_n; i++) begin
               walk_sum += tbl_count[i];
               if (walk_sum >= r.sample_number) begin
                  res.found_offset = tbl_offset[i];
                  res.status       = cort_pkg::ST_OK;
                  break;
               end
            end
         end
         cort_pkg::OP_READ: begin
            if (r.entry_index < used_n) begin
               res.found_offset = tbl_offset[r.entry_index];
               res.entry_run    = tbl_count[r.entry_index];
            end else begin
               res.status = cort_pkg::ST_BADINDEX;
            end
         end
         cort_pkg::OP_LOAD: begin
            if (used_n >= TABLE_DEPTH) begin
               res.status = cort_pkg::ST_FULL;
            end else begin
               tbl_count[used_n]  = r.run_count;
               tbl_offset[used_n] = r.offset;
               used_n++;
               run_open = 1'b0;
            end
         end
         cort_pkg::OP_CLEAR: begin
            used_n   = 0;
            run_open = 1'b0;
            last_sn  = '0;
         end
         default: ;
      endcase
      res.entries_used = used_n[8:0];
      res.final_sample = last_sn;
      return res;
   endfunction

   task automatic plan_check(input logic [2:0] op, input logic [31:0] sn, input logic [31:0] rc,
                             input logic [31:0] off, input logic [7:0] idx);
      plan_row_type row;
      row.req   = mk_req(op, sn, rc, off, idx);
      row.known = 1'b0;
      row.want  = '0;
      plan_q.push_back(row);
   endtask

   // Rows whose response is obvious: no offset or count is returned.
   task automatic plan_known(input logic [2:0] op, input logic [31:0] sn, input logic [31:0] rc,
                             input logic [31:0] off, input logic [7:0] idx, input logic [2:0] st,
                             input logic [8:0] used, input logic [31:0] fin);
      plan_row_type row;
      row.req   = mk_req(op, sn, rc, off, idx);
      row.known = 1'b1;
      row.want  = '0;
      row.want.status       = st;
      row.want.entries_used = used;
      row.want.final_sample = fin;
      plan_q.push_back(row);
   endtask

   // Presents one request, holding off at random first, and waits for its transaction.
   // The expectation is queued at the edge where the request is taken.
   task automatic issue(input offset_request_type r, input bit known,
                        input offset_result_type want);
      offset_result_type predicted;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.opcode;
      req_tdata  <= {r.entry_index, r.offset, r.run_count, r.sample_number};
      do @(posedge clock); while (!req_tready);
      predicted = apply_request(r);
      expected_results.push_back(known ? want : predicted);
   endtask

   // A random request shaped by the current table state: appends more often than any
   // other kind, keeping the sample numbers rising, with lookups and reads that land on
   // real entries, and a smaller share of out-of-order or overflowing appends, raw
   // loads, clears and unused codes.
   function automatic offset_request_type pick_mixed();
      int unsigned roll;
      logic [31:0] sn;
      logic [31:0] rc;
      logic [31:0] off;
      logic [7:0]  idx;
      roll = $urandom_range(99);
      sn   = $urandom;
      rc   = $urandom;
      off  = $urandom;
      idx  = 8'($urandom);
      // Once the sample numbers have climbed near the top, start again from empty.
      if (last_sn > 32'hFFFF_0000 && roll < 60) return mk_req(cort_pkg::OP_CLEAR, sn, rc, off, idx);
      if (roll < 38) begin
         case ($urandom_range(3))
            0:       off = '0;
            1:       off = open_offset();
            2:       off = 32'hFFFF_FFFF;
            default: off = $urandom;
         endcase
         if (last_sn != 0)
            sn = last_sn + 32'd1 + (($urandom_range(3) == 0) ? $urandom_range(1, 40) : 32'd0);
         rc = $urandom_range(0, 12);
         return mk_req(cort_pkg::OP_APPEND, sn, rc, off, idx);
      end
      if (roll < 44) begin
         if ($urandom_range(1) && last_sn != 0) begin
            sn = $urandom_range(0, last_sn);
         end else begin
            sn = last_sn + 32'd1;
            rc = 32'hFFFF_FFFF - $urandom_range(3);
         end
         return mk_req(cort_pkg::OP_APPEND, sn, rc, off, idx);
      end
      if (roll < 64) begin
         if ($urandom_range(1)) sn = $urandom_range(0, last_sn);
         return mk_req(cort_pkg::OP_LOOKUP, sn, rc, off, idx);
      end
      if (roll < 78) begin
         if (used_n > 0 && $urandom_range(4) != 0) idx = 8'($urandom_range(0, used_n - 1));
         return mk_req(cort_pkg::OP_READ, sn, rc, off, idx);
      end
      if (roll < 90) return mk_req(cort_pkg::OP_LOAD, sn, rc, off, idx);
      if (roll < 95) return mk_req(cort_pkg::OP_CLEAR, sn, rc, off, idx);
      return mk_req(3'($urandom_range(OP_SPARE, OP_SPARE_TOP)), sn, rc, off, idx);
   endfunction

   // Response side: tready drops at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic note_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= 10)
            $display("tb: %s mismatch, expected %0h, got %0h", field, want, got);
      end
   endtask

   // Each response transaction is compared, field by field, with the oldest expectation.
   always @(posedge clock) begin
      offset_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("tb: response with nothing outstanding, status %0h", rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            note_field("status", 32'(want.status), 32'(rsp_tuser));
            note_field("found_offset", want.found_offset, rsp_tdata[31:0]);
            note_field("entry_run", want.entry_run, rsp_tdata[63:32]);
            note_field("entries_used", 32'(want.entries_used), 32'(rsp_tdata[72:64]));
            note_field("final_sample", want.final_sample, rsp_tdata[104:73]);
         end
      end
   end

   // Watchdog: the run is abandoned once no transaction has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [31:0] fill_off;
      int          step;

      // Directed table. After reset the table is empty: a lookup misses, any index
      // is bad, and an unused code changes nothing.
      plan_known(cort_pkg::OP_LOOKUP, 32'd5, 32'd0, 32'd0, 8'd0, cort_pkg::ST_NOTFOUND,
                 9'd0, 32'd0);
      plan_known(cort_pkg::OP_READ, 32'd0, 32'd0, 32'd0, 8'd0, cort_pkg::ST_BADINDEX,
                 9'd0, 32'd0);
      plan_known(OP_SPARE, '1, '1, '1, '1, cort_pkg::ST_OK, 9'd0, 32'd0);
      // The first append ignores its sample number; the last sample becomes the count.
      plan_known(cort_pkg::OP_APPEND, 32'd0, 32'd10, -32'sd5, 8'd0, cort_pkg::ST_OK,
                 9'd1, 32'd10);
      // A sample number not above the last one is out of order.
      plan_known(cort_pkg::OP_APPEND, 32'd10, 32'd1, -32'sd5, 8'd0, cort_pkg::ST_ORDER,
                 9'd1, 32'd10);
      plan_check(cort_pkg::OP_APPEND, 32'd11, 32'd5, -32'sd5, 8'd0);          // merges
      plan_check(cort_pkg::OP_APPEND, 32'd20, 32'd3, 32'd7, 8'd0);   // zero-offset gap first
      plan_check(cort_pkg::OP_APPEND, 32'd23, 32'd0, 32'd9, 8'd0);   // empty run, no gap
      plan_check(cort_pkg::OP_APPEND, 32'd30, 32'd0, 32'd9, 8'd0);   // empty run, gap only
      plan_check(cort_pkg::OP_APPEND, 32'd30, 32'd4, 32'd0, 8'd0);   // joins the gap entry
      plan_check(cort_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0);
      plan_check(cort_pkg::OP_LOOKUP, 32'd16, 32'd0, 32'd0, 8'd0);
      plan_check(cort_pkg::OP_LOOKUP, 32'd33, 32'd0, 32'd0, 8'd0);
      plan_check(cort_pkg::OP_LOOKUP, 32'd34, 32'd0, 32'd0, 8'd0);   // just past the end
      plan_check(cort_pkg::OP_READ, 32'd0, 32'd0, 32'd0, 8'd3);
      plan_known(cort_pkg::OP_READ, 32'd0, 32'd0, 32'd0, 8'd255, cort_pkg::ST_BADINDEX,
                 9'd4, 32'd33);
      // A raw load closes the open run, so an append with the same offset opens another.
      plan_check(cort_pkg::OP_LOAD, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 8'd0);
      plan_check(cort_pkg::OP_APPEND, 32'd34, 32'd1, 32'h8000_0000, 8'd0);
      plan_check(cort_pkg::OP_APPEND, 32'hFFFF_FFF0, 32'h20, 32'h7FFF_FFFF, 8'd0); // overflows
      plan_check(cort_pkg::OP_APPEND, 32'hFFFF_FFF0, 32'h10, 32'h7FFF_FFFF, 8'd0); // ends on top
      plan_check(cort_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'd1, 32'd0, 8'd0);
      plan_check(cort_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0);
      plan_check(cort_pkg::OP_READ, 32'd0, 32'd0, 32'd0, 8'd7);
      plan_known(cort_pkg::OP_CLEAR, '1, '1, '1, '1, cort_pkg::ST_OK, 9'd0, 32'd0);
      plan_known(cort_pkg::OP_READ, 32'd0, 32'd0, 32'd0, 8'd0, cort_pkg::ST_BADINDEX,
                 9'd0, 32'd0);
      plan_known(OP_SPARE_TOP, 32'd0, 32'd0, 32'd0, 8'd0, cort_pkg::ST_OK, 9'd0, 32'd0);

      while (reset) @(posedge clock);

      foreach (plan_q[i]) issue(plan_q[i].req, plan_q[i].known, plan_q[i].want);

      // Mixed random traffic on a small table.
      for (step = 0; step < 50; step++) issue(pick_mixed(), 1'b0, '0);

      // Fill the table with one new entry per append, glancing at it now and then with
      // lookups and reads. The first half runs with no idling on either side.
      issue(mk_req(cort_pkg::OP_CLEAR, $urandom, $urandom, $urandom, 8'($urandom)), 1'b0, '0);
      steady <= 1'b1;
      step = 0;
      while (used_n < TABLE_DEPTH - 1) begin
         if (used_n >= TABLE_DEPTH / 2) steady <= 1'b0;
         step++;
         if (step % 16 == 0) begin
            issue(mk_req(cort_pkg::OP_LOOKUP, $urandom_range(0, last_sn), $urandom, $urandom,
                         8'($urandom)), 1'b0, '0);
         end else if (step % 16 == 8) begin
            issue(mk_req(cort_pkg::OP_READ, $urandom, $urandom, $urandom,
                         8'($urandom_range(0, used_n - 1))), 1'b0, '0);
         end else begin
            // An odd offset never equals the zero of a gap and differs from the open run.
            fill_off = $urandom | 32'd1;
            if (fill_off == open_offset()) fill_off ^= 32'h2;
            issue(mk_req(cort_pkg::OP_APPEND, last_sn + 32'd1, $urandom_range(1, 3), fill_off,
                         8'($urandom)), 1'b0, '0);
         end
      end
      steady <= 1'b0;

      // With one entry free, a gap followed by a new offset needs two and is refused.
      issue(mk_req(cort_pkg::OP_APPEND, last_sn + 32'd2, 32'd2, open_offset() ^ 32'h4,
                   8'($urandom)), 1'b0, '0);
      issue(mk_req(cort_pkg::OP_APPEND, last_sn + 32'd1, 32'd1, open_offset() ^ 32'h4,
                   8'($urandom)), 1'b0, '0);
      // The table is now full: a raw load or a new offset is refused, a merge still works.
      issue(mk_req(cort_pkg::OP_LOAD, $urandom, $urandom, $urandom, 8'($urandom)), 1'b0, '0);
      issue(mk_req(cort_pkg::OP_APPEND, last_sn + 32'd1, 32'd1, open_offset() ^ 32'h4,
                   8'($urandom)), 1'b0, '0);
      issue(mk_req(cort_pkg::OP_APPEND, last_sn + 32'd1, 32'd3, open_offset(), 8'($urandom)),
            1'b0, '0);
      issue(mk_req(cort_pkg::OP_APPEND, last_sn + 32'd1, 32'd0, $urandom, 8'($urandom)),
            1'b0, '0);
      // Lookups that walk every entry, one hitting the last and one missing.
      issue(mk_req(cort_pkg::OP_LOOKUP, last_sn, $urandom, $urandom, 8'($urandom)), 1'b0, '0);
      issue(mk_req(cort_pkg::OP_LOOKUP, last_sn + 32'd1, $urandom, $urandom, 8'($urandom)),
            1'b0, '0);
      issue(mk_req(cort_pkg::OP_READ, $urandom, $urandom, $urandom, 8'd255), 1'b0, '0);
      issue(mk_req(cort_pkg::OP_READ, $urandom, $urandom, $urandom, 8'($urandom)), 1'b0, '0);
      issue(mk_req(cort_pkg::OP_CLEAR, $urandom, $urandom, $urandom, 8'($urandom)), 1'b0, '0);

      for (step = 0; step < 30; step++) issue(pick_mixed(), 1'b0, '0);
      req_tvalid <= 1'b0;

      // Wait for every outstanding response, then a little longer for strays.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/cort_pkg.sv
design/cort_ctrl.sv
design/cort_dpath.sv
design/composition_offset_run_table.sv
design/cort_checker.sv
tb/tb_top.sv
